>>> sv/isrt_pkg.sv
// isrt_pkg: shared types and sizes for the insertion sorter.
// Used by isrt_cell, insertion_sorter and isrt_checker; no dependencies.
package isrt_pkg;

	localparam int MAX_ITEMS = 16;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_item;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last_result;
		logic               overflow;
	} out_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctrl_t;

endpackage

>>> sv/isrt_cell.sv
// isrt_cell: one slot of the sorted chain; holds a value and its valid bit.
// Depends on isrt_pkg.
module isrt_cell import isrt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] new_value,
	input  logic signed [31:0] left_value,
	input  logic               left_valid,
	input  logic               left_gt,
	input  logic signed [31:0] right_value,
	input  logic               right_valid,
	output logic signed [31:0] value,
	output logic               valid,
	output logic               gt
);

	logic signed [31:0] value_q;
	logic               valid_q;

	// an empty slot counts as greater so the new value lands at the end of the run
	assign gt    = !valid_q || (value_q > new_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end else if (ctrl.drain) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt) begin
				value_q <= new_value;
			end
		end else if (ctrl.drain) begin
			value_q <= right_value;
		end
	end

endmodule

>>> sv/insertion_sorter.sv
// Stable insertion sorter of signed 32-bit values over a chain of MAX_ITEMS cells.
// A request is taken on any cycle with start high and busy low, so a set loads at one
// value per clock: every cell compares against the new value in parallel and the
// greater ones shift up by one. The request flagged last_item ends the set; busy then
// rises and the n stored values leave from the bottom cell through a result register,
// one per cycle, with no gap. busy falls as the final result (last_result high) is
// shown, so a new set may start then.
// Values beyond MAX_ITEMS are dropped and every result of that set carries overflow.
// Results are strobed for one cycle and cannot be held off.
// Depends on isrt_pkg and isrt_cell.
module insertion_sorter import isrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic strobe,
	output out_t result
);

	logic signed [31:0] cell_value [MAX_ITEMS];
	logic               cell_valid [MAX_ITEMS];
	logic               cell_gt    [MAX_ITEMS];

	logic       drain_q;
	logic       dropped_q;
	logic       strobe_q;
	out_t       result_q;
	logic       accept;
	logic       full;
	cell_ctrl_t ctrl;

	assign accept      = start && !drain_q;
	assign full        = cell_valid[MAX_ITEMS-1];
	assign ctrl.insert = accept && !full;
	assign ctrl.drain  = drain_q;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [31:0] lv;
		logic               lval;
		logic               lgt;
		logic signed [31:0] rv;
		logic               rval;

		if (i == 0) begin : g_bot
			assign lv   = '0;
			assign lval = 1'b1;
			assign lgt  = 1'b0;
		end else begin : g_mid
			assign lv   = cell_value[i-1];
			assign lval = cell_valid[i-1];
			assign lgt  = cell_gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_top
			assign rv   = '0;
			assign rval = 1'b0;
		end else begin : g_low
			assign rv   = cell_value[i+1];
			assign rval = cell_valid[i+1];
		end

		isrt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (item.value),
			.left_value  (lv),
			.left_valid  (lval),
			.left_gt     (lgt),
			.right_value (rv),
			.right_valid (rval),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else if (drain_q) begin
			strobe_q <= 1'b1;
			// bottom cell holds the last value once its neighbour is empty
			if (!cell_valid[1]) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end else begin
			strobe_q <= 1'b0;
			if (accept) begin
				drain_q <= item.last_item;
				if (full) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q) begin
			result_q.value_res   <= cell_value[0];
			result_q.last_result <= !cell_valid[1];
			result_q.overflow    <= dropped_q;
		end
	end

	assign busy   = drain_q;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> sv/isrt_checker.sv
// isrt_checker: port-level checks on the insertion sorter, bound into insertion_sorter.
// Depends on isrt_pkg and insertion_sorter.
module isrt_checker import isrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  item,
	input logic strobe,
	input out_t result
);

	// results before the final one of a set only appear while busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |-> busy)
		else $error("non-final result shown while not busy");

	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last_result)
		else $error("busy dropped without the final result");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result |=> !strobe)
		else $error("result straight after the final result");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |=>
		strobe && (result.overflow == $past(result.overflow)))
		else $error("set burst broken or overflow changed within a set");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.last_item |=> !busy)
		else $error("busy raised by a request that does not end the set");

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.strobe (strobe),
	.result (result)
);
